FILE: rtl/core/lss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants for the LIFO stack with search: the stack depth,
// the operation and status codes, the controller states and the command
// structures passed between the controller, the cell chain and the cells.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_DUMP   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } state_t;

    // Command from the controller to the whole chain.
    typedef struct packed {
        logic push;
        logic pop;
        logic rot;
    } chain_cmd_t;

    // Per-cell load selection derived from the chain command.
    typedef struct packed {
        logic ld_above;
        logic ld_below;
        logic ld_top;
    } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/core/lss_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lss_cell
// One stack position: holds one entry, loads it from the neighbour above,
// the neighbour below or the top of the stack, and compares it with the key.
// ----------------------------------------------------------------------------
module lss_cell
    import lss_pkg::*;
(
    input  wire logic                     clk,
    input  wire cell_ctrl_t               ctrl,
    input  wire logic signed [DATA_W-1:0] above,
    input  wire logic signed [DATA_W-1:0] below,
    input  wire logic signed [DATA_W-1:0] top_val,
    input  wire logic signed [DATA_W-1:0] key,
    input  wire logic                     active,
    output logic signed [DATA_W-1:0]      data,
    output logic                          hit
);

    logic signed [DATA_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_above)
        begin
            data_reg <= above;
        end
        else if (ctrl.ld_top)
        begin
            data_reg <= top_val;
        end
        else if (ctrl.ld_below)
        begin
            data_reg <= below;
        end
    end

    assign data = data_reg;
    assign hit  = active && (data_reg == key);

endmodule
`default_nettype wire

FILE: rtl/core/lss_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lss_chain
// The row of stack cells, top entry in cell zero. Decodes the chain command
// into per-cell loads and gathers the search hits of the occupied cells.
// ----------------------------------------------------------------------------
module lss_chain
    import lss_pkg::*;
(
    input  wire logic                     clk,
    input  wire chain_cmd_t               cmd,
    input  wire logic [CNT_W-1:0]         count,
    input  wire logic signed [DATA_W-1:0] push_val,
    input  wire logic signed [DATA_W-1:0] key,
    output logic signed [DATA_W-1:0]      top_data,
    output logic                          any_hit
);

    logic signed [DATA_W-1:0] data_arr [DEPTH];
    logic [DEPTH-1:0]         hit_vec;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] POS      = CNT_W'(i);
        localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(i + 1);

        cell_ctrl_t               ctrl;
        logic signed [DATA_W-1:0] above;
        logic signed [DATA_W-1:0] below;

        // Pop and rotate move held entries up one place; in a rotation the
        // bottom held cell takes the old top so the stack comes back intact.
        assign ctrl.ld_above = cmd.push;
        assign ctrl.ld_below = (cmd.pop || cmd.rot) && (POS_NEXT < count);
        assign ctrl.ld_top   = cmd.rot && (POS_NEXT == count);

        if (i == 0)
        begin : g_first
            assign above = push_val;
        end
        else
        begin : g_inner
            assign above = data_arr[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign below = data_arr[i];
        end
        else
        begin : g_mid
            assign below = data_arr[i+1];
        end

        lss_cell u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .above   (above),
            .below   (below),
            .top_val (data_arr[0]),
            .key     (key),
            .active  (POS < count),
            .data    (data_arr[i]),
            .hit     (hit_vec[i])
        );
    end

    assign top_data = data_arr[0];
    assign any_hit  = |hit_vec;

endmodule
`default_nettype wire

FILE: rtl/core/lifo_stack_with_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// Bounded LIFO stack of signed 32-bit entries with push, pop, search and dump.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_ready, kind, value) takes one item
// naming an operation; the output channel (out_valid, out_ready, status,
// item, found, last) returns its results through a single output register.
// Push, pop and search give one result each, in the cycle after the item is
// accepted, and a new item may be taken in the cycle that result leaves, so
// these run at one item per cycle while the receiver keeps up. The search
// compares the key against every occupied cell of the chain in parallel.
// A dump of a stack holding N entries gives N results, top to bottom, one per
// cycle while the receiver keeps up, by rotating the cells; after N steps the
// stack is back in its original order. No new item is taken until the dump's
// last result has been loaded. An empty stack answers pop, search and dump
// with a single underflow result; a push to a full stack gives an overflow
// result and the value is dropped. Reset empties the stack and the output
// register; entry contents are not cleared. When the receiver stalls, the
// output register holds its result, the dump pauses and in_ready stays low.
// ----------------------------------------------------------------------------
module lifo_stack_with_search
    import lss_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               kind,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [1:0]                    status,
    output logic signed [DATA_W-1:0]      item,
    output logic                          found,
    output logic                          last
);

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         remain_reg, remain_next;
    logic                     out_valid_reg, out_valid_next;
    status_t                  status_reg, status_next;
    logic signed [DATA_W-1:0] item_reg, item_next;
    logic                     found_reg, found_next;
    logic                     last_reg, last_next;

    chain_cmd_t               cmd;
    logic signed [DATA_W-1:0] top_data;
    logic                     any_hit;
    logic                     out_free;
    logic                     accept;
    logic                     dump_step;
    logic                     empty;
    logic                     full;
    kind_t                    op;

    assign op        = kind_t'(kind);
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign dump_step = (state_reg == S_DUMP) && out_free;

    lss_chain u_chain (
        .clk      (clk),
        .cmd      (cmd),
        .count    (count_reg),
        .push_val (value),
        .key      (value),
        .top_data (top_data),
        .any_hit  (any_hit)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        item_next      = item_reg;
        found_next     = found_reg;
        last_next      = last_reg;
        cmd            = '0;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    item_next      = '0;
                    found_next     = 1'b0;
                    last_next      = 1'b1;
                    unique case (op)
                        KIND_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = ST_OVER;
                            end
                            else
                            begin
                                cmd.push   = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_POP:
                        begin
                            if (empty)
                            begin
                                status_next = ST_UNDER;
                            end
                            else
                            begin
                                cmd.pop    = 1'b1;
                                item_next  = top_data;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        KIND_SEARCH:
                        begin
                            if (empty)
                            begin
                                status_next = ST_UNDER;
                            end
                            else
                            begin
                                found_next = any_hit;
                            end
                        end
                        KIND_DUMP:
                        begin
                            if (empty)
                            begin
                                status_next = ST_UNDER;
                            end
                            else
                            begin
                                cmd.rot     = 1'b1;
                                item_next   = top_data;
                                last_next   = (count_reg == CNT_W'(1));
                                remain_next = count_reg - 1'b1;
                                if (count_reg != CNT_W'(1))
                                begin
                                    state_next = S_DUMP;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (dump_step)
                begin
                    cmd.rot        = 1'b1;
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    item_next      = top_data;
                    found_next     = 1'b0;
                    last_next      = (remain_reg == CNT_W'(1));
                    remain_next    = remain_reg - 1'b1;
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        item_reg   <= item_next;
        found_reg  <= found_next;
        last_reg   <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign item      = item_reg;
    assign found     = found_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("stack fill count exceeds depth");

    a_dump_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |-> (remain_reg != '0) && !in_ready)
        else $error("dump running with nothing left or input open");

    a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == KIND_PUSH) && full) |=> $stable(count_reg))
        else $error("push to full stack changed the fill count");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == KIND_POP) && !empty)
            |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not remove exactly one entry");

    a_dump_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP) |=> $stable(count_reg))
        else $error("dump changed the fill count");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb_lifo_stack_with_search.sv
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_search
// Self-checking testbench for the LIFO stack with push, pop, search and dump.
// A queue of operations, filled by the stimulus process, feeds a clocked
// driver. A clocked monitor predicts the results of every accepted item with
// a behavioural copy of the stack. It then compares each result the block
// hands over, field by field, against the oldest prediction. Both channels
// idle at random so that stalls land on every phase of a dump.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_search
    import lss_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Worst case is roughly 300 items, each a full dump of DEPTH results with
    // every result given the longest stall, plus the sender's gaps. This limit
    // leaves a wide margin over that.
    localparam int CYCLE_LIMIT = 200000;

    // One operation waiting to be offered to the block, together with the
    // number of idle cycles the sender inserts before offering it.
    typedef struct {
        kind_t                     kind;
        logic signed [DATA_W-1:0]  value;
        int unsigned               gap;
    } stack_op_t;

    // One predicted result item.
    typedef struct {
        status_t                   status;
        logic signed [DATA_W-1:0]  item;
        logic                      found;
        logic                      last;
    } stack_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [1:0]                kind;
    logic signed [DATA_W-1:0]  value;
    logic                      out_valid;
    logic                      out_ready;
    logic [1:0]                status;
    logic signed [DATA_W-1:0]  item;
    logic                      found;
    logic                      last;

    // Operations queued by the stimulus process, not yet offered.
    stack_op_t      pending_ops[$];
    // Results predicted for accepted items, oldest first.
    stack_result_t  expected_results[$];

    // The predictor's own copy of the stack.
    logic signed [DATA_W-1:0]  model_mem [DEPTH];
    int unsigned               model_fill;

    // A second copy kept at planning time, so that search keys can be chosen
    // from values that will really be held when the search arrives.
    logic signed [DATA_W-1:0]  plan_mem [DEPTH];
    int unsigned               plan_fill;

    // Handshake bookkeeping. Each counter has a single writer: the stimulus
    // process, the driver or the monitor.
    int unsigned  ops_queued;
    int unsigned  ops_launched;
    int unsigned  ops_accepted;
    int unsigned  results_taken;
    int unsigned  cycle_count;
    int unsigned  mismatch_count;
    stack_op_t    driven_op;

    // Upper bounds for the random idle cycles of each side, set per phase.
    int unsigned  in_idle_max;
    int unsigned  out_idle_max;

    lifo_stack_with_search i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .item      (item),
        .found     (found),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction: apply one accepted operation to the model stack and append
    // the result items it causes to the expectation queue.
    // ------------------------------------------------------------------------
    function automatic void predict_stack_op(input stack_op_t op);
        stack_result_t r;
        r.status = ST_OK;
        r.item   = '0;
        r.found  = 1'b0;
        r.last   = 1'b1;
        case (op.kind)
            KIND_PUSH:
            begin
                // A full stack drops the value and reports overflow.
                if (model_fill >= DEPTH)
                    r.status = ST_OVER;
                else
                begin
                    model_mem[model_fill] = op.value;
                    model_fill++;
                end
            end
            KIND_POP:
            begin
                if (model_fill == 0)
                    r.status = ST_UNDER;
                else
                begin
                    model_fill--;
                    r.item = model_mem[model_fill];
                end
            end
            KIND_SEARCH:
            begin
                if (model_fill == 0)
                    r.status = ST_UNDER;
                else
                    for (int i = 0; i < model_fill; i++)
                        if (model_mem[i] == op.value)
                            r.found = 1'b1;
            end
            default:
            begin
                // A dump of a non-empty stack gives one result per entry, top
                // first, with last set only on the bottom entry. The stack
                // itself is left as it was.
                if (model_fill == 0)
                    r.status = ST_UNDER;
                else
                begin
                    for (int i = model_fill; i > 0; i--)
                    begin
                        r.item = model_mem[i - 1];
                        r.last = (i == 1);
                        expected_results.push_back(r);
                    end
                    return;
                end
            end
        endcase
        expected_results.push_back(r);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // Driver. Inputs change on the falling edge only. An offered item stays
    // valid, unchanged, until the monitor has counted it as accepted. Before
    // each new item the sender waits the gap drawn for that item. The receiver
    // draws a fresh stall for every result it takes.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_ops
        stack_op_t    op;
        logic         nxt_valid;
        logic         gap_armed;
        int unsigned  gap_left;
        int unsigned  results_noted;
        int unsigned  out_stall;
        if (rst_n)
        begin
            nxt_valid = (ops_launched != ops_accepted);
            if (!nxt_valid && pending_ops.size() != 0)
            begin
                if (!gap_armed)
                begin
                    gap_left  = pending_ops[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left != 0)
                    gap_left--;
                else
                begin
                    op        = pending_ops.pop_front();
                    driven_op = op;
                    kind     <= op.kind;
                    value    <= op.value;
                    nxt_valid = 1'b1;
                    gap_armed = 1'b0;
                    ops_launched++;
                end
            end
            in_valid <= nxt_valid;

            if (results_taken != results_noted)
            begin
                results_noted = results_taken;
                out_stall     = $urandom_range(0, out_idle_max);
            end
            if (out_stall != 0)
            begin
                out_ready <= 1'b0;
                out_stall--;
            end
            else
                out_ready <= 1'b1;
        end
        else
        begin
            gap_armed     = 1'b0;
            gap_left      = 0;
            results_noted = 0;
            out_stall     = 0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled on the rising edge: an accepted result
    // item is compared against the oldest expectation, and an accepted input
    // item is then run through the predictor.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_results
        stack_result_t want;
        if (rst_n)
        begin
            cycle_count++;
            if (out_valid && out_ready)
            begin
                results_taken++;
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result status=%0d item=%0d",
                                              status, item));
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  status, want.status));
                    if (item !== want.item)
                        report_mismatch($sformatf("item %0d, wanted %0d",
                                                  item, want.item));
                    if (found !== want.found)
                        report_mismatch($sformatf("found %0b, wanted %0b",
                                                  found, want.found));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %0b, wanted %0b",
                                                  last, want.last));
                end
            end
            if (in_valid && in_ready)
            begin
                predict_stack_op(driven_op);
                ops_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Queue one operation and keep the planning copy of the stack in step.
    task automatic queue_op(input kind_t k, input logic signed [DATA_W-1:0] v);
        stack_op_t op;
        op.kind  = k;
        op.value = v;
        op.gap   = $urandom_range(0, in_idle_max);
        pending_ops.push_back(op);
        ops_queued++;
        if (k == KIND_PUSH && plan_fill < DEPTH)
        begin
            plan_mem[plan_fill] = v;
            plan_fill++;
        end
        else if (k == KIND_POP && plan_fill != 0)
            plan_fill--;
    endtask

    // Values with a bias towards the extremes and a small pool, so that
    // duplicates and search hits are common.
    function automatic logic signed [DATA_W-1:0] rand_value();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom;
        else if (sel < 7)
            return $urandom_range(0, 7);
        else if (sel < 8)
            return -$signed({29'd0, 3'($urandom_range(1, 7))});
        else
            case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return '0;
                default: return '1;
            endcase
    endfunction

    // Half of the searches on a non-empty stack look for a value that will be held.
    function automatic logic signed [DATA_W-1:0] search_key();
        if (plan_fill != 0 && $urandom_range(0, 1) == 1)
            return plan_mem[$urandom_range(0, plan_fill - 1)];
        return rand_value();
    endfunction

    // Random operations in runs: push runs that can drive the stack into
    // overflow, pop runs that can take it down into underflow, and mixed runs
    // that search and dump at varying fill levels.
    task automatic queue_random_ops(input int unsigned count);
        int unsigned n;
        int unsigned run;
        int unsigned style;
        int unsigned pick;
        n = 0;
        while (n < count)
        begin
            style = $urandom_range(0, 9);
            run   = $urandom_range(1, 18);
            for (int i = 0; i < run && n < count; i++)
            begin
                pick = $urandom_range(0, 99);
                if (style < 3)
                    queue_op(KIND_PUSH, rand_value());
                else if (style < 5)
                    queue_op(KIND_POP, $urandom);
                else if (pick < 40)
                    queue_op(KIND_PUSH, rand_value());
                else if (pick < 65)
                    queue_op(KIND_POP, $urandom);
                else if (pick < 90)
                    queue_op(KIND_SEARCH, search_key());
                else
                    queue_op(KIND_DUMP, $urandom);
                n++;
            end
        end
    endtask

    // Hold back further stimulus until every queued item has been accepted
    // and every predicted result has arrived.
    task automatic wait_drained();
        while (ops_accepted != ops_queued || expected_results.size() != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : run_test
        logic signed [DATA_W-1:0] absent_key;
        logic                     is_held;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        kind           = KIND_PUSH;
        value          = '0;
        out_ready      = 1'b0;
        model_fill     = 0;
        plan_fill      = 0;
        ops_queued     = 0;
        ops_launched   = 0;
        ops_accepted   = 0;
        results_taken  = 0;
        cycle_count    = 0;
        mismatch_count = 0;
        in_idle_max    = 2;
        out_idle_max   = 2;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Every operation is tried on the empty stack first.
        // The stack is then filled with the field extremes and random values
        // until full, pushed once more to overflow, searched for a hit and a
        // miss, and dumped at full depth, then popped and pushed once more.
        queue_op(KIND_POP, 32'sh7fff_ffff);
        queue_op(KIND_SEARCH, 32'sh8000_0000);
        queue_op(KIND_DUMP, '1);
        queue_op(KIND_PUSH, 32'sh8000_0000);
        queue_op(KIND_PUSH, 32'sh7fff_ffff);
        queue_op(KIND_PUSH, '0);
        queue_op(KIND_PUSH, '1);
        while (plan_fill < DEPTH)
            queue_op(KIND_PUSH, $urandom);
        queue_op(KIND_PUSH, 32'sh1234_5678);
        queue_op(KIND_SEARCH, 32'sh7fff_ffff);
        do
        begin
            absent_key = $urandom;
            is_held    = 1'b0;
            for (int i = 0; i < plan_fill; i++)
                if (plan_mem[i] == absent_key)
                    is_held = 1'b1;
        end
        while (is_held);
        queue_op(KIND_SEARCH, absent_key);
        queue_op(KIND_DUMP, '0);
        queue_op(KIND_POP, '0);
        queue_op(KIND_PUSH, '1);
        wait_drained();

        // Random part in four phases: no idling on either side, idling on
        // both, a stalling receiver alone and a slow sender alone. Between
        // phases the sender pauses until every result has come back.
        in_idle_max  = 0;
        out_idle_max = 0;
        queue_random_ops(59);
        wait_drained();

        in_idle_max  = 4;
        out_idle_max = 4;
        queue_random_ops(59);
        wait_drained();

        in_idle_max  = 0;
        out_idle_max = 4;
        queue_random_ops(59);
        wait_drained();

        in_idle_max  = 4;
        out_idle_max = 0;
        queue_random_ops(59);
        wait_drained();

        // A few more cycles catch any stray result after the last one.
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: a hang, or an expectation that never arrives, ends here.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("[%0t] timeout after %0d cycles", $time, cycle_count);
        $display("FAIL");
        $finish;
    end

endmodule
